// ===== rtl/gn3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gn3_pkg
// Shared constants and the gradient function for the gradient noise core.
// ---------------------------------------------------------------------------
package gn3_pkg;
   localparam int TableBits = 8;
   localparam logic CmdLoad = 1'b0;
   localparam logic CmdEval = 1'b1;
   localparam longint OutMax = 131071;
   localparam longint OutMin = -131072;

   // gradient select: h & 15, 12 and 14 reuse x
   function automatic logic signed [63:0] grad(input logic [3:0] h,
      input logic signed [63:0] x, input logic signed [63:0] y,
      input logic signed [63:0] z);
      logic signed [63:0] u;
      logic signed [63:0] v;
      u = (h < 4'd8) ? x : y;
      v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/gn3_fade.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gn3_fade
// Quintic fade curve over three registered multiply stages.
// ---------------------------------------------------------------------------
module gn3_fade #(
   parameter int FracBits = 16
) (
   input  wire                        clock,
   input  wire                        adv,
   input  wire  [FracBits-1:0]        t_in,
   output logic signed [FracBits+2:0] fade_out
);
   localparam int W = FracBits + 3;
   // inner term reaches 10.0, so it needs two more bits
   localparam int WI = FracBits + 5;
   localparam longint One = 64'sd1 <<< FracBits;
   logic signed [W-1:0] t1_ff, sq_ff, cube_ff, f_ff;
   logic signed [WI-1:0] inner_ff, inner2_ff;
   logic signed [63:0] p_in, s_in, c_in, f_in;
   always_comb begin
      s_in = (64'(signed'({1'b0, t_in})) * 64'(signed'({1'b0, t_in}))) >>> FracBits;
      p_in = ((64'(signed'({1'b0, t_in})) * (64'(signed'({1'b0, t_in})) * 6 - 15 * One))
         >>> FracBits) + 10 * One;
      c_in = (64'(sq_ff) * 64'(t1_ff)) >>> FracBits;
      f_in = (64'(cube_ff) * 64'(inner2_ff)) >>> FracBits;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= W'(signed'({1'b0, t_in}));
         sq_ff <= W'(s_in);
         inner_ff <= WI'(p_in);
         cube_ff <= W'(c_in);
         inner2_ff <= inner_ff;
         f_ff <= W'(f_in);
      end
   end
   assign fade_out = f_ff;
endmodule
`default_nettype wire

// ===== rtl/gradient_noise_3d_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle unless the output stalls; loads take a slot and give no result.
// The pipeline advances as a whole; a stall on a valid result holds every stage.
// Reset clears all valid bits; the permutation table is not cleared and
// must be loaded in full before the first evaluation.
// Table reads: three stages read private table copies, each written by a load
// as it passes that stage.
// ---------------------------------------------------------------------------
// gradient_noise_3d_core
// Improved 3-D gradient noise evaluator, fully pipelined.
// ---------------------------------------------------------------------------
module gradient_noise_3d_core #(
   parameter int FracBits = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire                      req_cmd,
   input  wire  [7:0]               req_table_index,
   input  wire  [7:0]               req_table_value,
   input  wire  signed [31:0]       req_coord_x,
   input  wire  signed [31:0]       req_coord_y,
   input  wire  signed [31:0]       req_coord_z,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic signed [17:0]       rsp_noise_value
);
   localparam int Depth = 9;
   localparam longint One = 64'sd1 <<< FracBits;
   localparam int W = FracBits + 3;

   // valid bits travel with the data; advance when the output is free
   logic [Depth-1:0] vld_ff;
   logic [2:0] ld_ff;
   logic adv;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   logic acc;
   assign acc = req_valid && adv && (req_cmd == gn3_pkg::CmdEval);
   logic acc_load;
   assign acc_load = req_valid && adv && (req_cmd == gn3_pkg::CmdLoad);

   // stage 0: split coordinates, capture load fields
   logic [7:0] cx0_ff, cy0_ff, cz0_ff, cy1_ff, cz1_ff, cz2_ff;
   logic [FracBits-1:0] fx0_ff, fy0_ff, fz0_ff;
   logic [7:0] idx_ff [3], val_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         cx0_ff <= req_coord_x[FracBits+7:FracBits];
         cy0_ff <= req_coord_y[FracBits+7:FracBits];
         cz0_ff <= req_coord_z[FracBits+7:FracBits];
         fx0_ff <= req_coord_x[FracBits-1:0];
         fy0_ff <= req_coord_y[FracBits-1:0];
         fz0_ff <= req_coord_z[FracBits-1:0];
         idx_ff[0] <= req_table_index;
         val_ff[0] <= req_table_value;
         for (int i = 1; i < 3; i++) begin
            idx_ff[i] <= idx_ff[i-1];
            val_ff[i] <= val_ff[i-1];
         end
         cy1_ff <= cy0_ff;
         cz1_ff <= cz0_ff;
         cz2_ff <= cz1_ff;
      end
   end

   // fade units, 3 stages from stage 0 output
   logic signed [W-1:0] u_w, v_w, w_w;
   gn3_fade #(.FracBits(FracBits)) u_fx (.clock, .adv, .t_in(fx0_ff), .fade_out(u_w));
   gn3_fade #(.FracBits(FracBits)) u_fy (.clock, .adv, .t_in(fy0_ff), .fade_out(v_w));
   gn3_fade #(.FracBits(FracBits)) u_fz (.clock, .adv, .t_in(fz0_ff), .fade_out(w_w));

   // hash stages 1..3 in parallel with fade
   // copy 0 reads the cell x pair, copies 1-2 the a/b rows, copies 3-6 the
   // corner pairs; each read returns entry n and n+1 from a register
   logic [6:0][7:0] ra_w;
   wire  [6:0][7:0] da_w, db_w;
   logic [7:0][3:0] hash_w;
   always_comb begin
      ra_w[0] = cx0_ff;
      ra_w[1] = da_w[0] + cy1_ff;
      ra_w[2] = db_w[0] + cy1_ff;
      ra_w[3] = da_w[1] + cz2_ff;
      ra_w[4] = da_w[2] + cz2_ff;
      ra_w[5] = db_w[1] + cz2_ff;
      ra_w[6] = db_w[2] + cz2_ff;
      for (int i = 0; i < 4; i++) begin
         hash_w[i] = da_w[3+i][3:0];
         hash_w[i+4] = db_w[3+i][3:0];
      end
   end

   genvar gi;
   for (gi = 0; gi < 7; gi++) begin : g_perm
      // a load writes this copy from the stage that reads it, so order holds
      localparam int Stage = (gi == 0) ? 0 : ((gi < 3) ? 1 : 2);
      logic [7:0] perm_ff [1 << gn3_pkg::TableBits];
      logic [7:0] da_ff, db_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (ld_ff[Stage]) perm_ff[idx_ff[Stage]] <= val_ff[Stage];
            da_ff <= perm_ff[ra_w[gi]];
            db_ff <= perm_ff[8'(ra_w[gi] + 8'd1)];
         end
      end
      assign da_w[gi] = da_ff;
      assign db_w[gi] = db_ff;
   end

   logic [FracBits-1:0] fx_d_ff [3], fy_d_ff [3], fz_d_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         fx_d_ff[0] <= fx0_ff; fy_d_ff[0] <= fy0_ff; fz_d_ff[0] <= fz0_ff;
         for (int i = 1; i < 3; i++) begin
            fx_d_ff[i] <= fx_d_ff[i-1];
            fy_d_ff[i] <= fy_d_ff[i-1];
            fz_d_ff[i] <= fz_d_ff[i-1];
         end
      end
   end

   // stage 4: gradients (fade ready at same time)
   logic signed [W-1:0] g4_ff [8];
   logic signed [W-1:0] u4_ff, v4_ff, w4_ff, v5_ff, w5_ff, w6_ff;
   logic signed [63:0] fx, fy, fz;
   assign fx = 64'(signed'({1'b0, fx_d_ff[2]}));
   assign fy = 64'(signed'({1'b0, fy_d_ff[2]}));
   assign fz = 64'(signed'({1'b0, fz_d_ff[2]}));
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 8; i++)
            g4_ff[i] <= W'(gn3_pkg::grad(hash_w[i],
               i[0] ? fx - One : fx, i[1] ? fy - One : fy, i[2] ? fz - One : fz));
         u4_ff <= u_w; v4_ff <= v_w; w4_ff <= w_w;
         v5_ff <= v4_ff; w5_ff <= w4_ff; w6_ff <= w5_ff;
      end
   end

   // lerp stages 5, 6, 7
   logic signed [W-1:0] l5_ff [4], l6_ff [2], l7_ff;
   function automatic logic signed [W-1:0] lerp(input logic signed [W-1:0] t,
      input logic signed [W-1:0] a, input logic signed [W-1:0] b);
      logic signed [63:0] d;
      d = 64'(b) - 64'(a);
      return W'(64'(a) + ((64'(t) * d) >>> FracBits));
   endfunction
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) l5_ff[i] <= lerp(u4_ff, g4_ff[2*i], g4_ff[2*i+1]);
         for (int i = 0; i < 2; i++) l6_ff[i] <= lerp(v5_ff, l5_ff[2*i], l5_ff[2*i+1]);
         l7_ff <= lerp(w6_ff, l6_ff[0], l6_ff[1]);
      end
   end

   // stage 8: rescale to Q1.16 and saturate
   logic signed [63:0] r;
   always_comb begin
      if (FracBits > 16)
         r = (64'(l7_ff) + (64'sd1 <<< (FracBits - 17))) >>> (FracBits - 16);
      else
         r = 64'(l7_ff) <<< (16 - FracBits);
      if (r > gn3_pkg::OutMax) r = gn3_pkg::OutMax;
      if (r < gn3_pkg::OutMin) r = gn3_pkg::OutMin;
   end
   always_ff @(posedge clock) begin
      if (adv) rsp_noise_value <= 18'(r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         ld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], acc};
         ld_ff <= {ld_ff[1:0], acc_load};
      end
   end
   assign rsp_valid = vld_ff[Depth-1];

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("result changed under stall");
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == gn3_pkg::CmdLoad |=> !vld_ff[0])
      else $error("load produced a result slot");
   a_slot_single: assert property (@(posedge clock) disable iff (reset)
      !(ld_ff[0] && vld_ff[0]))
      else $error("stage 0 holds a load and an evaluation");
`endif
endmodule
`default_nettype wire

// ===== tb/gradient_noise_3d_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gradient_noise_3d_core_tb
// Loads a full permutation table, walks a short table of directed requests,
// then streams random loads and evaluations with random gaps and stalls.
// Every result is checked: typed rows carry their own answer, the rest use a fixed-point noise predictor in this file.
// ---------------------------------------------------------------------------
module gradient_noise_3d_core_tb;

   localparam int Frac = 16;
   localparam longint One = 64'sd1 <<< Frac;
   localparam int RandomItems = 1080;
   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_cmd;
   logic [7:0] req_table_index;
   logic [7:0] req_table_value;
   logic signed [31:0] req_coord_x;
   logic signed [31:0] req_coord_y;
   logic signed [31:0] req_coord_z;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [17:0] rsp_noise_value;

   // One row of directed stimulus; typed rows carry their own answer.
   typedef struct {
      logic cmd;
      logic [7:0] index;
      logic [7:0] value;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      bit typed;
      logic signed [17:0] answer;
   } row_type;

   logic [7:0] perm_copy [256];
   logic signed [17:0] noise_expected [$];
   int errors = 0;
   int cycles = 0;
   int results_seen = 0;
   int loads_sent = 0;
   int evals_sent = 0;
   bit quiet_phase = 0;   // no random gaps or stalls while set, bar the one long hold
   bit stimulus_done = 0;

   gradient_noise_3d_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_table_index(req_table_index), .req_table_value(req_table_value),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_noise_value(rsp_noise_value)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Fixed-point noise predictor
   // ---------------------------------------------------------------------
   // product of two Q.16 values, floored (>>> on a signed longint floors)
   function automatic longint mul_q(longint a, longint b);
      return (a * b) >>> Frac;
   endfunction

   function automatic longint fade_curve(longint t);
      longint inner;
      longint cube;
      inner = mul_q(t, 6 * t - 15 * One) + 10 * One;
      cube = mul_q(mul_q(t, t), t);
      return mul_q(cube, inner);
   endfunction

   function automatic longint blend(longint t, longint a, longint b);
      return a + mul_q(t, b - a);
   endfunction

   // corner gradient dot product: low 4 hash bits pick the direction
   function automatic longint corner_dot(logic [7:0] hash, longint x, longint y,
                                         longint z);
      logic [3:0] h;
      longint u;
      longint v;
      h = hash[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic logic [7:0] perm_at(int i);
      return perm_copy[i & 255];
   endfunction

   function automatic logic signed [17:0] noise_at(logic [31:0] rx, logic [31:0] ry,
                                                   logic [31:0] rz);
      int cx, cy, cz, a, aa, ab, b, ba, bb;
      longint fx, fy, fz, u, v, w, r;
      cx = int'(rx[Frac+7:Frac]);
      cy = int'(ry[Frac+7:Frac]);
      cz = int'(rz[Frac+7:Frac]);
      fx = longint'(rx[Frac-1:0]);
      fy = longint'(ry[Frac-1:0]);
      fz = longint'(rz[Frac-1:0]);
      u = fade_curve(fx);
      v = fade_curve(fy);
      w = fade_curve(fz);
      a = (perm_at(cx) + cy) & 255;
      aa = (perm_at(a) + cz) & 255;
      ab = (perm_at(a + 1) + cz) & 255;
      b = (perm_at(cx + 1) + cy) & 255;
      ba = (perm_at(b) + cz) & 255;
      bb = (perm_at(b + 1) + cz) & 255;
      r = blend(w,
            blend(v,
               blend(u, corner_dot(perm_at(aa), fx, fy, fz),
                        corner_dot(perm_at(ba), fx - One, fy, fz)),
               blend(u, corner_dot(perm_at(ab), fx, fy - One, fz),
                        corner_dot(perm_at(bb), fx - One, fy - One, fz))),
            blend(v,
               blend(u, corner_dot(perm_at(aa + 1), fx, fy, fz - One),
                        corner_dot(perm_at(ba + 1), fx - One, fy, fz - One)),
               blend(u, corner_dot(perm_at(ab + 1), fx, fy - One, fz - One),
                        corner_dot(perm_at(bb + 1), fx - One, fy - One,
                                   fz - One))));
      // saturate to the Q1.16 output range
      if (r > gn3_pkg::OutMax) r = gn3_pkg::OutMax;
      if (r < gn3_pkg::OutMin) r = gn3_pkg::OutMin;
      return r[17:0];
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offer one request after a random gap, hold it until accepted, then
   // record the load in the table copy or queue the expected noise value.
   task automatic send_request(row_type rq);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= rq.cmd;
      req_table_index <= rq.index;
      req_table_value <= rq.value;
      req_coord_x <= rq.x;
      req_coord_y <= rq.y;
      req_coord_z <= rq.z;
      do @(posedge clock); while (req_stall);
      if (rq.cmd == gn3_pkg::CmdLoad) begin
         perm_copy[rq.index] = rq.value;
         loads_sent++;
      end else begin
         noise_expected.push_back(rq.typed ? rq.answer
                                           : noise_at(rq.x, rq.y, rq.z));
         evals_sent++;
      end
      @(negedge clock);
   endtask

   function automatic row_type load_row(logic [7:0] index, logic [7:0] value);
      row_type rq;
      rq = '{gn3_pkg::CmdLoad, index, value, $urandom, $urandom, $urandom, 0, 0};
      return rq;
   endfunction

   function automatic row_type eval_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        bit typed, logic signed [17:0] answer);
      row_type rq;
      rq = '{gn3_pkg::CmdEval, 8'($urandom), 8'($urandom), x, y, z, typed, answer};
      return rq;
   endfunction

   // random coordinate: full range, near the origin, or on a lattice point
   function automatic logic [31:0] random_coord();
      logic [31:0] c;
      c = $urandom;
      case ($urandom_range(0, 3))
         0: c = {{12{c[31]}}, c[19:0]};
         1: c[15:0] = 16'h0000;
         default: ;
      endcase
      return c;
   endfunction

   row_type directed [$];

   initial begin
      logic [7:0] shuffle [256];
      int j;
      logic [7:0] tmp;
      row_type rq;

      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = gn3_pkg::CmdLoad;
      req_table_index = '0;
      req_table_value = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every entry with a shuffled permutation before any evaluation
      for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = shuffle[i];
         shuffle[i] = shuffle[j];
         shuffle[j] = tmp;
      end
      for (int i = 0; i < 256; i++) send_request(load_row(8'(i), shuffle[i]));

      // lattice points give zero whatever the table holds; the rest of the
      // rows exercise fraction extremes and loads at the index extremes
      directed.push_back(eval_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 0));
      directed.push_back(eval_row(32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, 1, 0));
      directed.push_back(eval_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0));
      directed.push_back(eval_row(32'hFFFF_0000, 32'h0001_0000, 32'h00FF_0000, 1, 0));
      directed.push_back(eval_row(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 0, 0));
      directed.push_back(eval_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
      directed.push_back(eval_row(32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_8000, 0, 0));
      directed.push_back(eval_row(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 0));
      directed.push_back(eval_row(32'h00FF_0001, 32'h0000_0001, 32'hFF00_FFFF, 0, 0));
      directed.push_back(load_row(8'd0, 8'd255));
      directed.push_back(load_row(8'd255, 8'd0));
      directed.push_back(load_row(8'd1, 8'd255));
      directed.push_back(eval_row(32'h0000_4000, 32'h00FF_C000, 32'h00FF_2000, 0, 0));
      directed.push_back(eval_row(32'h00FF_8000, 32'h0000_8000, 32'h0000_8000, 0, 0));
      directed.push_back(eval_row(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 0, 0));
      directed.push_back(eval_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 0, 0));
      foreach (directed[k]) send_request(directed[k]);

      // random part: mostly evaluations, with table rewrites mixed in
      for (int n = 0; n < RandomItems; n++) begin
         if (n % 64 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) rq = load_row(8'($urandom), 8'($urandom));
         else rq = eval_row(random_coord(), random_coord(), random_coord(), 0, 0);
         send_request(rq);
      end
      req_valid <= 1'b0;
      stimulus_done = 1;
   end

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   // Stall for a random count before each result; once, after a few hundred
   // results, hold off long enough that the pipeline backs up into req_stall.
   initial begin
      int hold;
      bit long_hold_done;
      long_hold_done = 0;
      rsp_stall = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         hold = quiet_phase ? 0 : $urandom_range(0, 6);
         if (!long_hold_done && results_seen >= 300) begin
            hold = 150;
            long_hold_done = 1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (noise_expected.size() == 0) begin
            $error("unexpected result: noise_value actual %0d", rsp_noise_value);
            errors++;
         end else begin
            if (rsp_noise_value !== noise_expected[0]) begin
               $error("noise_value mismatch: expected %0d actual %0d",
                      noise_expected[0], rsp_noise_value);
               errors++;
            end
            void'(noise_expected.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("gradient_noise_3d_core test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // End of run
   // ---------------------------------------------------------------------
   initial begin
      wait (stimulus_done);
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (noise_expected.size() != 0) begin
         $error("%0d expected results never arrived", noise_expected.size());
         errors++;
      end
      $display("covered %0d table loads and %0d noise evaluations, %0d results",
               loads_sent, evals_sent, results_seen);
      $display("random gaps and stalls plus one long output hold; %0d errors", errors);
      if (errors == 0) begin
         $display("gradient_noise_3d_core test passed");
      end else begin
         $display("gradient_noise_3d_core test failed");
      end
      $finish;
   end
endmodule
